[rtl/ptb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, sizes and codes for the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

  // number of timer slots and the width of a slot index
  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // field widths
  localparam int KIND_W   = 2;
  localparam int ELAPSE_W = 16;
  localparam int ID_W     = 16;
  localparam int CNT_W    = 24;
  localparam int WAIT_W   = 10;
  localparam int GSLOT_W  = 3;

  // cap on the reported wait
  localparam logic [WAIT_W-1:0] WAIT_CAP = 10'd1000;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CREATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // result kinds
  localparam logic [1:0] RK_EXPIRY = 2'd0;
  localparam logic [1:0] RK_WAIT   = 2'd1;
  localparam logic [1:0] RK_CREATE = 2'd2;
  localparam logic [1:0] RK_DELETE = 2'd3;

  // one slot of the timer table
  typedef struct packed {
    logic             used;
    logic [ID_W-1:0]  ident;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] period;
  } slot_t;

endpackage
`default_nettype wire

[rtl/ptb_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_cell
// One timer slot of the rotating ring: takes its neighbor's slot on a shift,
// or is written by create / cleared by delete while the ring stands still.
// ----------------------------------------------------------------------------
module ptb_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        shift,
  input  wire ptb_pkg::slot_t              nb_in,
  input  wire logic                        wr,
  input  wire logic [ptb_pkg::ID_W-1:0]    wr_ident,
  input  wire logic [ptb_pkg::CNT_W-1:0]   wr_period,
  input  wire logic                        clr,
  output ptb_pkg::slot_t                   q
);

  logic                        used_r;
  logic [ptb_pkg::ID_W-1:0]    ident_r;
  logic [ptb_pkg::CNT_W-1:0]   count_r;
  logic [ptb_pkg::CNT_W-1:0]   period_r;

  // occupancy bit, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (shift) begin
      used_r <= nb_in.used;
    end else if (wr) begin
      used_r <= 1'b1;
    end else if (clr) begin
      used_r <= 1'b0;
    end
  end

  // timer payload, valid only while used
  always_ff @(posedge clk) begin
    if (shift) begin
      ident_r  <= nb_in.ident;
      count_r  <= nb_in.count;
      period_r <= nb_in.period;
    end else if (wr) begin
      ident_r  <= wr_ident;
      count_r  <= '0;
      period_r <= wr_period;
    end
  end

  assign q.used   = used_r;
  assign q.ident  = ident_r;
  assign q.count  = count_r;
  assign q.period = period_r;

endmodule
`default_nettype wire

[rtl/ptb_head.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_head
// Update unit at the end of the ring: ages the slot passing by, flags an
// expiry and keeps the running minimum of the remaining counters.
// ----------------------------------------------------------------------------
module ptb_head (
  input  wire logic                          clk,
  input  wire logic                          start,
  input  wire logic [ptb_pkg::ELAPSE_W-1:0]  elapsed,
  input  wire logic                          step,
  input  wire ptb_pkg::slot_t                slot_in,
  output ptb_pkg::slot_t                     slot_out,
  output logic                               fire,
  output logic [ptb_pkg::ID_W-1:0]           fire_id,
  output logic [ptb_pkg::WAIT_W-1:0]         best
);

  logic [ptb_pkg::ELAPSE_W-1:0] elapsed_r;
  logic [ptb_pkg::WAIT_W-1:0]   best_r;
  logic [ptb_pkg::WAIT_W-1:0]   best_nxt;
  logic [ptb_pkg::CNT_W-1:0]    elapsed_x;
  logic [ptb_pkg::CNT_W-1:0]    count_new;

  assign elapsed_x = ptb_pkg::CNT_W'(elapsed_r);

  // age one slot: reload on zero or on expiry, else count down
  always_comb begin
    fire      = 1'b0;
    count_new = slot_in.count;
    if (slot_in.used) begin
      if (slot_in.count == '0) begin
        count_new = slot_in.period;
      end else if (elapsed_x >= slot_in.count) begin
        count_new = slot_in.period;
        fire      = 1'b1;
      end else begin
        count_new = slot_in.count - elapsed_x;
      end
    end
  end

  // running minimum over used slots
  always_comb begin
    best_nxt = best_r;
    if (slot_in.used && (count_new < ptb_pkg::CNT_W'(best_r))) begin
      best_nxt = count_new[ptb_pkg::WAIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      elapsed_r <= elapsed;
      best_r    <= ptb_pkg::WAIT_CAP;
    end else if (step) begin
      best_r    <= best_nxt;
    end
  end

  assign slot_out.used   = slot_in.used;
  assign slot_out.ident  = slot_in.ident;
  assign slot_out.count  = count_new;
  assign slot_out.period = slot_in.period;
  assign fire_id         = slot_in.ident;
  assign best            = best_r;

endmodule
`default_nettype wire

[rtl/periodic_timer_bank_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_bank_core
// Bank of periodic timers in a fixed slot table, kept in a rotating ring.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one word per item: tick (elapsed), create (timer_id, period)
//   or delete (slot). out_* returns result words; the last one of each item
//   has out_last set. Both channels use valid/stall.
//   Create and delete answer one word in the cycle after acceptance.
//   A tick rotates the slot ring once through the update unit: SLOTS steps,
//   one slot per cycle in slot order while out_stall does not hold the ring,
//   each expiring slot giving one expiry word, then comes the next wait
//   word. Items are taken one at a time.
//   A stall on out_stall with a word pending freezes the ring; nothing is
//   dropped. in_stall is high while an item is in progress or the output
//   word is held.
//   Reset (rst_n low, synchronous) empties every slot and clears the output.
//   Kind 3 is taken and ignored.
// ----------------------------------------------------------------------------
module periodic_timer_bank_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ptb_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [ptb_pkg::ELAPSE_W-1:0]  in_elapsed,
  input  wire logic [ptb_pkg::ID_W-1:0]      in_timer_id,
  input  wire logic [ptb_pkg::CNT_W-1:0]     in_period,
  input  wire logic [ptb_pkg::GSLOT_W-1:0]   in_slot,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_result_kind,
  output logic [ptb_pkg::ID_W-1:0]           out_fired_id,
  output logic [ptb_pkg::WAIT_W-1:0]         out_wait_ticks,
  output logic [ptb_pkg::GSLOT_W-1:0]        out_given_slot,
  output logic                               out_ok,
  output logic                               out_last
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WAIT} state_t;

  state_t                          state_r;
  logic [ptb_pkg::SLOT_W-1:0]      pos_r;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic [1:0]                      out_kind_r;
  logic [ptb_pkg::ID_W-1:0]        out_id_r;
  logic [ptb_pkg::WAIT_W-1:0]      out_wait_r;
  logic [ptb_pkg::GSLOT_W-1:0]     out_gslot_r;
  logic                            out_ok_r;
  logic                            out_last_r;

  logic                            out_free;
  logic                            in_acc;
  logic                            step;
  logic                            is_create;
  logic                            is_delete;
  logic                            any_free;
  int                              found;
  logic [ptb_pkg::SLOTS-1:0]       used_vec;
  ptb_pkg::slot_t                  ring_q [ptb_pkg::SLOTS];
  ptb_pkg::slot_t                  head_out;
  logic                            fire;
  logic [ptb_pkg::ID_W-1:0]        fire_id;
  logic [ptb_pkg::WAIT_W-1:0]      best;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign step      = (state_r == ST_SCAN) && out_free;
  assign is_create = in_acc && (in_kind == ptb_pkg::KIND_CREATE);
  assign is_delete = in_acc && (in_kind == ptb_pkg::KIND_DELETE);

  // lowest free slot
  always_comb begin
    found    = 0;
    any_free = 1'b0;
    for (int i = ptb_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_vec[i]) begin
        found    = i;
        any_free = 1'b1;
      end
    end
  end

  // slot ring: each cell takes its upper neighbor, the top one takes the head
  for (genvar g = 0; g < ptb_pkg::SLOTS; g++) begin : g_ring
    ptb_pkg::slot_t nb;
    if (g == ptb_pkg::SLOTS - 1) begin : g_top
      assign nb = head_out;
    end else begin : g_mid
      assign nb = ring_q[g+1];
    end
    assign used_vec[g] = ring_q[g].used;

    ptb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (step),
      .nb_in     (nb),
      .wr        (is_create && any_free && (found == g)),
      .wr_ident  (in_timer_id),
      .wr_period (in_period),
      .clr       (is_delete && (32'(in_slot) == g)),
      .q         (ring_q[g])
    );
  end

  // update unit on the slot leaving the bottom of the ring
  ptb_head u_head (
    .clk      (clk),
    .start    (in_acc && (in_kind == ptb_pkg::KIND_TICK)),
    .elapsed  (in_elapsed),
    .step     (step),
    .slot_in  (ring_q[0]),
    .slot_out (head_out),
    .fire     (fire),
    .fire_id  (fire_id),
    .best     (best)
  );

  // output word present next cycle: held while stalled or newly loaded
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (is_create || is_delete) begin
      out_valid_nxt = 1'b1;
    end
    if (step && fire) begin
      out_valid_nxt = 1'b1;
    end
    if ((state_r == ST_WAIT) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // sequencer and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      out_kind_r  <= ptb_pkg::RK_EXPIRY;
      out_id_r    <= '0;
      out_wait_r  <= '0;
      out_gslot_r <= '0;
      out_ok_r    <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_kind)
              ptb_pkg::KIND_TICK: begin
                state_r <= ST_SCAN;
                pos_r   <= '0;
              end
              ptb_pkg::KIND_CREATE: begin
                out_kind_r  <= ptb_pkg::RK_CREATE;
                out_id_r    <= '0;
                out_wait_r  <= '0;
                out_gslot_r <= any_free ? ptb_pkg::GSLOT_W'(found) : '0;
                out_ok_r    <= any_free;
                out_last_r  <= 1'b1;
              end
              ptb_pkg::KIND_DELETE: begin
                out_kind_r  <= ptb_pkg::RK_DELETE;
                out_id_r    <= '0;
                out_wait_r  <= '0;
                out_gslot_r <= '0;
                out_ok_r    <= 1'b0;
                out_last_r  <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (step) begin
            if (fire) begin
              out_kind_r  <= ptb_pkg::RK_EXPIRY;
              out_id_r    <= fire_id;
              out_wait_r  <= '0;
              out_gslot_r <= '0;
              out_ok_r    <= 1'b0;
              out_last_r  <= 1'b0;
            end
            pos_r <= pos_r + 1'b1;
            if (pos_r == ptb_pkg::SLOT_W'(ptb_pkg::SLOTS - 1)) begin
              state_r <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            out_kind_r  <= ptb_pkg::RK_WAIT;
            out_id_r    <= '0;
            out_wait_r  <= best;
            out_gslot_r <= '0;
            out_ok_r    <= 1'b0;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_fired_id    = out_id_r;
  assign out_wait_ticks  = out_wait_r;
  assign out_given_slot  = out_gslot_r;
  assign out_ok          = out_ok_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

[rtl/ptb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_checker
// Port-level checks for the periodic timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module ptb_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [1:0]                    out_result_kind,
  input  wire logic [ptb_pkg::WAIT_W-1:0]    out_wait_ticks,
  input  wire logic [ptb_pkg::GSLOT_W-1:0]   out_given_slot,
  input  wire logic                          out_ok,
  input  wire logic                          out_last
);

  // output empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present after reset");

  // a held word stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // an expiry word never closes an item
  a_expiry_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == ptb_pkg::RK_EXPIRY) |-> !out_last)
    else $error("expiry word marked last");

  // the wait word closes the tick and stays within the cap
  a_wait_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == ptb_pkg::RK_WAIT)
      |-> out_last && (out_wait_ticks <= ptb_pkg::WAIT_CAP))
    else $error("bad next wait word");

  // a failed create reports slot zero
  a_create_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == ptb_pkg::RK_CREATE) && !out_ok
      |-> (out_given_slot == '0) && out_last)
    else $error("failed create reports a slot");

endmodule

bind periodic_timer_bank_core ptb_checker u_ptb_checker (.*);
`default_nettype wire
